[sv/indexed_circular_deque_assert.svh]
// Assertion macros used by the port-level checker of the indexed circular deque.
`ifndef INDEXED_CIRCULAR_DEQUE_ASSERT_SVH
`define INDEXED_CIRCULAR_DEQUE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define IDQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define IDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/idq_pkg.sv]
// Shared constants, types and helper functions of the indexed circular deque.
package idq_pkg;

  // Storage geometry.
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int SUM_W      = CNT_W + 1;

  // Request and response field widths.
  localparam int OP_W   = 3;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_FIELDS_W   = OP_W + POS_W + DATA_WIDTH;
  localparam int OUT_FIELDS_W  = DATA_WIDTH + STAT_W + CNT_W;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_STAT_LSB  = DATA_WIDTH;
  localparam int OUT_FILL_LSB  = DATA_WIDTH + STAT_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH_LOW  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_HIGH = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_LOW   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_HIGH  = 3'd3;
  localparam logic [OP_W-1:0] OP_GET       = 3'd4;
  localparam logic [OP_W-1:0] OP_PUT       = 3'd5;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // decode the request, update head and fill
    logic access;  // read (and write) the slot store
    logic load;    // move the result into the output register
  } idq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } idq_sts_t;

  // Physical slot of a pointer plus an offset, wrapping at the capacity.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(ptr) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return PTR_W'(sum);
  endfunction

endpackage

[sv/idq_ctrl.sv]
// Controller state machine of the indexed circular deque.
module idq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  idq_pkg::idq_sts_t sts,
  output idq_pkg::idq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ACCESS = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_ACCESS;
        end
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/idq_datapath.sv]
// Datapath of the indexed circular deque: pointers, slot store and output register.
module idq_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  idq_pkg::idq_cmd_t                   cmd,
  output idq_pkg::idq_sts_t                   sts,
  input  logic [idq_pkg::OP_W-1:0]            opcode,
  input  logic [idq_pkg::POS_W-1:0]           position,
  input  logic [idq_pkg::DATA_WIDTH-1:0]      data_in,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [idq_pkg::DATA_WIDTH-1:0]      data_out,
  output logic [idq_pkg::STAT_W-1:0]          status,
  output logic [idq_pkg::CNT_W-1:0]           fill_level
);

  // Slot store.
  logic [idq_pkg::DATA_WIDTH-1:0] mem [idq_pkg::CAPACITY];

  // Pointer state.
  logic [idq_pkg::PTR_W-1:0]      head_r, head_nxt;
  logic [idq_pkg::CNT_W-1:0]      fill_r, fill_nxt;

  // Decoded request held for the access and result cycles.
  logic [idq_pkg::PTR_W-1:0]      addr_r, addr_nxt;
  logic                           wr_en_r, wr_en_nxt;
  logic                           use_rd_r, use_rd_nxt;
  logic                           use_din_r, use_din_nxt;
  logic [idq_pkg::STAT_W-1:0]     stat_r, stat_nxt;
  logic [idq_pkg::DATA_WIDTH-1:0] din_r;
  logic [idq_pkg::DATA_WIDTH-1:0] rd_data_r;

  // Output register.
  logic                           out_valid_r;
  logic [idq_pkg::DATA_WIDTH-1:0] out_data_r;
  logic [idq_pkg::STAT_W-1:0]     out_stat_r;
  logic [idq_pkg::CNT_W-1:0]      out_fill_r;

  logic                           is_full;
  logic                           is_empty;
  logic                           pos_ok;
  logic [idq_pkg::PTR_W-1:0]      head_dec;
  logic [idq_pkg::PTR_W-1:0]      head_inc;

  assign is_full  = (fill_r == idq_pkg::CNT_W'(idq_pkg::CAPACITY));
  assign is_empty = (fill_r == '0);
  assign pos_ok   = (idq_pkg::CMP_W'(position) < idq_pkg::CMP_W'(fill_r));
  assign head_dec = (head_r == '0) ? idq_pkg::PTR_W'(idq_pkg::CAPACITY - 1)
                                   : head_r - 1'b1;
  assign head_inc = (head_r == idq_pkg::PTR_W'(idq_pkg::CAPACITY - 1)) ? '0
                                                                        : head_r + 1'b1;

  // Request decode: slot address, pointer updates and status.
  always_comb begin
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    addr_nxt    = head_r;
    wr_en_nxt   = 1'b0;
    use_rd_nxt  = 1'b0;
    use_din_nxt = 1'b0;
    stat_nxt    = idq_pkg::ST_OK;
    unique case (opcode)
      idq_pkg::OP_PUSH_LOW: begin
        if (is_full) begin
          stat_nxt = idq_pkg::ST_FULL;
        end else begin
          head_nxt    = head_dec;
          addr_nxt    = head_dec;
          fill_nxt    = fill_r + 1'b1;
          wr_en_nxt   = 1'b1;
          use_din_nxt = 1'b1;
        end
      end
      idq_pkg::OP_PUSH_HIGH: begin
        if (is_full) begin
          stat_nxt = idq_pkg::ST_FULL;
        end else begin
          addr_nxt    = idq_pkg::wrap_add(head_r, fill_r);
          fill_nxt    = fill_r + 1'b1;
          wr_en_nxt   = 1'b1;
          use_din_nxt = 1'b1;
        end
      end
      idq_pkg::OP_POP_LOW: begin
        if (is_empty) begin
          stat_nxt = idq_pkg::ST_EMPTY;
        end else begin
          addr_nxt   = head_r;
          head_nxt   = head_inc;
          fill_nxt   = fill_r - 1'b1;
          use_rd_nxt = 1'b1;
        end
      end
      idq_pkg::OP_POP_HIGH: begin
        if (is_empty) begin
          stat_nxt = idq_pkg::ST_EMPTY;
        end else begin
          addr_nxt   = idq_pkg::wrap_add(head_r, fill_r - 1'b1);
          fill_nxt   = fill_r - 1'b1;
          use_rd_nxt = 1'b1;
        end
      end
      idq_pkg::OP_GET: begin
        if (!pos_ok) begin
          stat_nxt = idq_pkg::ST_RANGE;
        end else begin
          addr_nxt   = idq_pkg::wrap_add(head_r, idq_pkg::CNT_W'(position));
          use_rd_nxt = 1'b1;
        end
      end
      idq_pkg::OP_PUT: begin
        if (!pos_ok) begin
          stat_nxt = idq_pkg::ST_RANGE;
        end else begin
          addr_nxt   = idq_pkg::wrap_add(head_r, idq_pkg::CNT_W'(position));
          wr_en_nxt  = 1'b1;
          use_rd_nxt = 1'b1;
        end
      end
      default: begin
        // Unused codes leave everything unchanged and answer ok with zero data.
        stat_nxt = idq_pkg::ST_OK;
      end
    endcase
  end

  // Pointer state, updated when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else if (cmd.accept) begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Decoded request, held until the result is loaded.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r    <= addr_nxt;
      wr_en_r   <= wr_en_nxt;
      use_rd_r  <= use_rd_nxt;
      use_din_r <= use_din_nxt;
      stat_r    <= stat_nxt;
      din_r     <= data_in;
    end
  end

  // Single-port store: the registered read returns the old value on a put.
  always_ff @(posedge clk) begin
    if (cmd.access) begin
      rd_data_r <= mem[addr_r];
      if (wr_en_r) begin
        mem[addr_r] <= din_r;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (use_rd_r) begin
        out_data_r <= rd_data_r;
      end else if (use_din_r) begin
        out_data_r <= din_r;
      end else begin
        out_data_r <= '0;
      end
      out_stat_r <= stat_r;
      out_fill_r <= fill_r;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign data_out     = out_data_r;
  assign status       = out_stat_r;
  assign fill_level   = out_fill_r;

endmodule

[sv/indexed_circular_deque.sv]
// Top level of the indexed circular deque: stream ports, controller and datapath.
//
// A fixed-capacity double-ended queue of 16 words of 32 bits with a head
// pointer and a fill count. Each request pushes or pops at either end, reads
// the element at a logical index, or overwrites it and returns the old value;
// exactly one response follows each request, in order. Pushes on a full store,
// pops on an empty one and indexes at or past the fill level report a status
// code, return zero data and change nothing. A request is decoded in the cycle
// that accepts it, accesses the single-port slot store with its registered
// read in the next cycle, and is then loaded into the output register once
// that register is free. The block takes no new request until the previous
// one is loaded. A response waiting in the output register does not block
// acceptance of the next request; the load of that request waits as long as
// the waiting response is held. Unused opcodes answer ok with zero data.
module indexed_circular_deque (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] opcode, [6:3] position, [38:7] data_in, [39] zero
  input  logic [idq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] data_out, [33:32] status, [38:34] fill_level, [39] zero
  output logic [idq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  idq_pkg::idq_cmd_t              cmd;
  idq_pkg::idq_sts_t              sts;
  logic [idq_pkg::OP_W-1:0]       opcode;
  logic [idq_pkg::POS_W-1:0]      position;
  logic [idq_pkg::DATA_WIDTH-1:0] data_in;
  logic [idq_pkg::DATA_WIDTH-1:0] data_out;
  logic [idq_pkg::STAT_W-1:0]     status;
  logic [idq_pkg::CNT_W-1:0]      fill_level;

  // Unpack the request fields.
  assign opcode   = in_tdata[idq_pkg::OP_W-1:0];
  assign position = in_tdata[idq_pkg::OP_W +: idq_pkg::POS_W];
  assign data_in  = in_tdata[idq_pkg::OP_W + idq_pkg::POS_W +: idq_pkg::DATA_WIDTH];

  // Pack the response fields, zero padded to whole bytes.
  assign out_tdata = idq_pkg::OUT_TDATA_W'({fill_level, status, data_out});

  idq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  idq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (opcode),
    .position   (position),
    .data_in    (data_in),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .data_out   (data_out),
    .status     (status),
    .fill_level (fill_level)
  );

endmodule

[sv/idq_checker.sv]
// Port-level checker of the indexed circular deque and its bind to the top level.
`include "indexed_circular_deque_assert.svh"

module idq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [idq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [idq_pkg::DATA_WIDTH-1:0] rsp_data;
  logic [idq_pkg::STAT_W-1:0]     rsp_stat;
  logic [idq_pkg::CNT_W-1:0]      rsp_fill;
  logic                           in_fire;
  logic                           out_stall;
  logic                           rsp_err;
  logic                           rsp_full;
  logic                           rsp_empty;
  logic                           at_cap;

  assign rsp_data  = out_tdata[idq_pkg::DATA_WIDTH-1:0];
  assign rsp_stat  = out_tdata[idq_pkg::OUT_STAT_LSB +: idq_pkg::STAT_W];
  assign rsp_fill  = out_tdata[idq_pkg::OUT_FILL_LSB +: idq_pkg::CNT_W];
  assign in_fire   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign rsp_err   = out_tvalid && (rsp_stat != idq_pkg::ST_OK);
  assign rsp_full  = out_tvalid && (rsp_stat == idq_pkg::ST_FULL);
  assign rsp_empty = out_tvalid && (rsp_stat == idq_pkg::ST_EMPTY);
  assign at_cap    = (rsp_fill == idq_pkg::CNT_W'(idq_pkg::CAPACITY));

  // A stalled response holds its transaction.
  `IDQ_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "response not held")

  // Failed requests return zero data.
  `IDQ_ASSERT_SAME(a_err_zero, rsp_err, rsp_data == '0, "error response carries data")

  // A full report comes only from a store at capacity.
  `IDQ_ASSERT_SAME(a_full_level, rsp_full, at_cap, "full status below capacity")

  // An empty report comes only from an empty store.
  `IDQ_ASSERT_SAME(a_empty_level, rsp_empty, rsp_fill == '0, "empty status with stored elements")

  // The block does not accept requests back to back.
  `IDQ_ASSERT_NEXT(a_in_gap, in_fire, !in_tready, "requests accepted back to back")

endmodule

bind indexed_circular_deque idq_checker u_idq_checker (.*);

[tb/idq_response_checker.sv]
// Response checker for the indexed circular deque: predicts each response and compares it.
module idq_response_checker
  import idq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // [2:0] opcode, [6:3] position, [38:7] data_in, [39] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] data_out, [33:32] status, [38:34] fill_level, [39] zero
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_total,
  output int                     outstanding,
  output int                     responses_seen,
  output int                     full_seen,
  output int                     empty_seen,
  output int                     range_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] word;
    logic [STAT_W-1:0]     status;
    logic [CNT_W-1:0]      level;
  } deque_resp_t;

  // Shadow copy of the deque contents and pointers.
  logic [DATA_WIDTH-1:0] slot_mem [CAPACITY];
  logic [PTR_W-1:0]      head_ptr;
  logic [CNT_W-1:0]      count;

  // Responses predicted but not yet seen, oldest first.
  deque_resp_t pending_q [$];

  int n_fail = 0;
  int n_resp = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_range = 0;

  // Physical slot that holds a logical index.
  function automatic int slot_of(input int logical);
    return (int'(head_ptr) + logical) % CAPACITY;
  endfunction

  // Applies one request to the shadow deque and returns the response it must produce.
  function automatic deque_resp_t apply_request(input logic [OP_W-1:0]       op,
                                                input logic [POS_W-1:0]      pos,
                                                input logic [DATA_WIDTH-1:0] val);
    deque_resp_t r;
    int s;
    r = '0;
    case (op)
      OP_PUSH_LOW, OP_PUSH_HIGH: begin
        if (count == CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_LOW) begin
            head_ptr = (head_ptr == 0) ? PTR_W'(CAPACITY - 1) : head_ptr - 1'b1;
            s = head_ptr;
          end else begin
            s = slot_of(count);
          end
          slot_mem[s] = val;
          count = count + 1'b1;
          r.word = val;
        end
      end
      OP_POP_LOW: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = slot_mem[head_ptr];
          head_ptr = PTR_W'((int'(head_ptr) + 1) % CAPACITY);
          count = count - 1'b1;
        end
      end
      OP_POP_HIGH: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          count = count - 1'b1;
          r.word = slot_mem[slot_of(count)];
        end
      end
      OP_GET, OP_PUT: begin
        if (CNT_W'(pos) >= count) begin
          r.status = ST_RANGE;
        end else begin
          s = slot_of(pos);
          r.word = slot_mem[s];
          if (op == OP_PUT) begin
            slot_mem[s] = val;
          end
        end
      end
      // Unused opcodes answer ok with zero data and leave the deque alone.
      default: ;
    endcase
    r.level = count;
    return r;
  endfunction

  // Reports one differing field; returns 1 on a mismatch.
  function automatic int field_bad(input string name, input logic [DATA_WIDTH-1:0] want_v,
                                   input logic [DATA_WIDTH-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  // Check the response transaction first, then queue the prediction for a new request.
  always @(posedge clk) begin : watch
    deque_resp_t got;
    deque_resp_t want;
    if (!rst_n) begin
      pending_q.delete();
      head_ptr = '0;
      count    = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.word   = out_tdata[DATA_WIDTH-1:0];
        got.status = out_tdata[OUT_STAT_LSB +: STAT_W];
        got.level  = out_tdata[OUT_FILL_LSB +: CNT_W];
        n_resp++;
        case (got.status)
          ST_FULL:  n_full++;
          ST_EMPTY: n_empty++;
          ST_RANGE: n_range++;
          default:  ;
        endcase
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual data %h status %0d fill %0d",
                   $time, got.word, got.status, got.level);
          n_fail++;
        end else begin
          want = pending_q.pop_front();
          n_fail += field_bad("data_out", want.word, got.word);
          n_fail += field_bad("status", DATA_WIDTH'(want.status), DATA_WIDTH'(got.status));
          n_fail += field_bad("fill_level", DATA_WIDTH'(want.level), DATA_WIDTH'(got.level));
        end
      end
      if (in_tvalid && in_tready) begin
        pending_q.push_back(apply_request(in_tdata[OP_W-1:0], in_tdata[OP_W +: POS_W],
                                          in_tdata[OP_W + POS_W +: DATA_WIDTH]));
      end
    end
    fail_total     <= n_fail;
    outstanding    <= pending_q.size();
    responses_seen <= n_resp;
    full_seen      <= n_full;
    empty_seen     <= n_empty;
    range_seen     <= n_range;
  end

endmodule

[tb/tb.sv]
// Testbench top for the indexed circular deque: clock, reset, request and ready stimulus, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import idq_pkg::*;

  localparam int ITEMS       = 1750;
  localparam int CALM_TAIL   = 150;
  localparam int CYCLE_LIMIT = 400000;

  // Opcodes that the block must ignore.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // Traffic mixes of the random part.
  localparam int MIX_FILL   = 0;
  localparam int MIX_DRAIN  = 1;
  localparam int MIX_ACCESS = 2;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_total;
  int outstanding;
  int responses_seen;
  int full_seen;
  int empty_seen;
  int range_seen;

  int   sent = 0;
  int   directed_count = 0;
  int   est_fill = 0;
  int   cycle_count = 0;
  logic calm = 1'b0;

  indexed_circular_deque dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  idq_response_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_total    (fail_total),
    .outstanding   (outstanding),
    .responses_seen(responses_seen),
    .full_seen     (full_seen),
    .empty_seen    (empty_seen),
    .range_seen    (range_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("indexed_circular_deque test failed");
      $finish;
    end
  end

  // Offers one request and returns at the edge that accepts the transaction.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [DATA_WIDTH-1:0] val);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({val, pos, op});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (sent >= ITEMS - CALM_TAIL) begin
      calm <= 1'b1;
    end
    // Rough fill estimate, used only to aim indexes at live elements.
    case (op)
      OP_PUSH_LOW, OP_PUSH_HIGH: if (est_fill < CAPACITY) est_fill++;
      OP_POP_LOW, OP_POP_HIGH:   if (est_fill > 0) est_fill--;
      default: ;
    endcase
  endtask

  // Holds the request side idle until every predicted response has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [OP_W-1:0] pick_op(input int mix);
    int r;
    int push_w;
    int pop_w;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin push_w = 30; pop_w = 10; end
      MIX_DRAIN: begin push_w = 10; pop_w = 30; end
      default:   begin push_w = 10; pop_w = 10; end
    endcase
    if (r < 2) return ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
    r = r - 2;
    if (r < push_w) return OP_PUSH_LOW;
    r = r - push_w;
    if (r < push_w) return OP_PUSH_HIGH;
    r = r - push_w;
    if (r < pop_w) return OP_POP_LOW;
    r = r - pop_w;
    if (r < pop_w) return OP_POP_HIGH;
    return ($urandom_range(0, 1) != 0) ? OP_PUT : OP_GET;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  // Mostly indexes of live elements, sometimes anything the field allows.
  function automatic logic [POS_W-1:0] pick_pos();
    if (est_fill > 0 && $urandom_range(0, 4) != 0) begin
      return POS_W'($urandom_range(0, est_fill - 1));
    end
    return POS_W'($urandom_range(0, 15));
  endfunction

  // Response side: ready with random stall bursts, none in the tail of the run.
  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
      if (!calm) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // Request side: reset, directed corner cases, random traffic, drain and verdict.
  initial begin
    int mix;
    int seg_len;
    int k;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    rst_n     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty deque: both pops, indexed access and an ignored opcode.
    send_item(OP_POP_LOW, 4'h0, '0);
    send_item(OP_POP_HIGH, 4'hf, '1);
    send_item(OP_GET, 4'h0, '0);
    send_item(OP_PUT, 4'hf, '1);
    send_item(OP_SPARE_LO, 4'hf, '1);
    // Fill to capacity from both ends, wrapping the head below slot zero.
    for (k = 0; k < CAPACITY; k++) begin
      case (k)
        0:       send_item(OP_PUSH_LOW, 4'h0, '0);
        1:       send_item(OP_PUSH_HIGH, 4'hf, '1);
        default: send_item((k % 2 != 0) ? OP_PUSH_HIGH : OP_PUSH_LOW, POS_W'(k),
                           DATA_WIDTH'($urandom));
      endcase
    end
    // Full deque: pushes refused, last index reachable, overwrite at the low end.
    send_item(OP_PUSH_HIGH, 4'h3, 32'h8000_0001);
    send_item(OP_PUSH_LOW, 4'hc, 32'h7fff_fffe);
    send_item(OP_GET, 4'hf, 32'h1234_5678);
    send_item(OP_PUT, 4'h0, 32'h5a5a_a5a5);
    send_item(OP_SPARE_HI, 4'h0, '0);
    directed_count = sent;

    // Random traffic in segments that push the deque toward full, empty or heavy access.
    while (sent < ITEMS) begin
      mix     = $urandom_range(MIX_FILL, MIX_ACCESS);
      seg_len = $urandom_range(20, 80);
      for (k = 0; k < seg_len && sent < ITEMS; k++) begin
        if (sent == ITEMS / 2) begin
          wait_drained();
        end
        send_item(pick_op(mix), pick_pos(), pick_word());
      end
      if (!calm && $urandom_range(0, 7) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d requests (%0d directed) and checked %0d responses.",
             sent, directed_count, responses_seen);
    $display("Refusals seen: %0d full, %0d empty, %0d index out of range.",
             full_seen, empty_seen, range_seen);
    if (fail_total == 0 && outstanding == 0) begin
      $display("indexed_circular_deque test passed");
    end else begin
      $display("indexed_circular_deque test failed");
    end
    $finish;
  end

endmodule
